### rtl/core/kthmh_pkg.sv
// Package: types, constants and codes for the k-th smallest selection unit.
package kthmh_pkg;

  localparam int DEF_CAPACITY = 1024;
  localparam int VALUE_W      = 32;
  localparam int RANK_W       = 11;
  localparam int STATUS_W     = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         rank;
    logic                      last;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] kth_value;
    logic [STATUS_W-1:0]       status;
    logic                      overflowed;
  } result_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_LOAD   = 2'b01,
    S_SELECT = 2'b10
  } state_t;

endpackage

### rtl/core/kth_smallest_min_heap_unit.sv
// Top level: k-th smallest selection over a sorted chain of cells.
//
//  channel   | handshake          | payload              | direction
//  ----------+--------------------+----------------------+----------
//  command   | start / busy       | cmd   (cmd_t)        | in
//  result    | done (1-cycle)     | result (result_t)    | out
//
// Values load one per cycle; each enters its sorted place in the chain, or is dropped once it is full.
// On the last value, if the rank is in range, the chain shifts toward the head
// max(rank,1)-1 times, one cell per cycle; then done rises with the result.
// A rank error skips the shifts and gives a zero value. busy drops with done.
// Reset (rst, synchronous) empties the set. The receiver cannot stall.
module kth_smallest_min_heap_unit #(
  parameter int CAPACITY = kthmh_pkg::DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  kthmh_pkg::cmd_t    cmd,
  output logic               done,
  output kthmh_pkg::result_t result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > kthmh_pkg::RANK_W) ? CNT_W : kthmh_pkg::RANK_W;

  kthmh_pkg::state_t                        state;
  logic [CNT_W-1:0]                         count;
  logic                                     overflow;
  logic [kthmh_pkg::RANK_W-1:0]             remaining;
  logic [kthmh_pkg::STATUS_W-1:0]           status;
  kthmh_pkg::cell_ctrl_t                    ctrl;
  logic                                     accept;
  logic                                     has_room;
  logic [CNT_W-1:0]                         count_next;
  logic [kthmh_pkg::RANK_W-1:0]             rank_eff;
  logic [kthmh_pkg::STATUS_W-1:0]           status_next;

  logic signed [kthmh_pkg::VALUE_W-1:0]     vals [CAPACITY];
  logic                                     lts  [CAPACITY];

  assign busy       = (state != kthmh_pkg::S_LOAD);
  assign accept     = start && !busy;
  assign has_room   = (count < CNT_W'(CAPACITY));
  assign count_next = has_room ? count + CNT_W'(1) : count;
  assign rank_eff   = (cmd.rank == '0) ? kthmh_pkg::RANK_W'(1) : cmd.rank;

  always_comb begin
    if (count_next == '0) begin
      status_next = kthmh_pkg::STATUS_EMPTY;
    end else if (CMP_W'(rank_eff) > CMP_W'(count_next)) begin
      status_next = kthmh_pkg::STATUS_RANGE;
    end else begin
      status_next = kthmh_pkg::STATUS_OK;
    end
  end

  always_comb begin
    ctrl.insert = accept && has_room;
    ctrl.shift  = (state == kthmh_pkg::S_SELECT) && (status == kthmh_pkg::STATUS_OK)
                  && (remaining != '0);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [kthmh_pkg::VALUE_W-1:0] prev_v;
    logic                                 prev_l;
    logic signed [kthmh_pkg::VALUE_W-1:0] next_v;

    if (i == 0) begin : g_head
      assign prev_v = cmd.value;
      assign prev_l = 1'b0;
    end else begin : g_body
      assign prev_v = vals[i-1];
      assign prev_l = lts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_v = vals[i];
    end else begin : g_mid
      assign next_v = vals[i+1];
    end

    kthmh_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (count),
      .din      (cmd.value),
      .prev_val (prev_v),
      .prev_lt  (prev_l),
      .next_val (next_v),
      .val      (vals[i]),
      .lt       (lts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kthmh_pkg::S_LOAD;
      count    <= '0;
      overflow <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        kthmh_pkg::S_LOAD: begin
          if (accept) begin
            count    <= count_next;
            overflow <= overflow || !has_room;
            if (cmd.last) begin
              status    <= status_next;
              remaining <= rank_eff - kthmh_pkg::RANK_W'(1);
              state     <= kthmh_pkg::S_SELECT;
            end
          end
        end
        kthmh_pkg::S_SELECT: begin
          if (ctrl.shift) begin
            remaining <= remaining - kthmh_pkg::RANK_W'(1);
          end else begin
            done              <= 1'b1;
            result.kth_value  <= (status == kthmh_pkg::STATUS_OK) ? vals[0] : '0;
            result.status     <= status;
            result.overflowed <= overflow;
            count             <= '0;
            overflow          <= 1'b0;
            state             <= kthmh_pkg::S_LOAD;
          end
        end
        default: begin
          state <= kthmh_pkg::S_LOAD;
        end
      endcase
    end
  end

endmodule

### rtl/core/kthmh_cell.sv
// One cell of the sorted chain: holds one value, inserts in order, shifts toward the head.
module kthmh_cell #(
  parameter int CNT_W = 11,
  parameter int IDX   = 0
) (
  input  logic                                   clk,
  input  kthmh_pkg::cell_ctrl_t                  ctrl,
  input  logic [CNT_W-1:0]                       count,
  input  logic signed [kthmh_pkg::VALUE_W-1:0]   din,
  input  logic signed [kthmh_pkg::VALUE_W-1:0]   prev_val,
  input  logic                                   prev_lt,
  input  logic signed [kthmh_pkg::VALUE_W-1:0]   next_val,
  output logic signed [kthmh_pkg::VALUE_W-1:0]   val,
  output logic                                   lt
);

  logic occupied;

  assign occupied = (count > CNT_W'(IDX));
  assign lt       = !occupied || (din < val);

  always_ff @(posedge clk) begin
    if (ctrl.insert && lt) begin
      val <= prev_lt ? prev_val : din;
    end else if (ctrl.shift) begin
      val <= next_val;
    end
  end

endmodule
